>>> hdl/krsc_pkg.sv
// Shared types and constants for the key rank success check.
// Stand-alone package; imported by key_rank_success_check.
package krsc_pkg;

	localparam int KEY_COUNT_DEF  = 256;
	localparam int SCORE_BITS_DEF = 32;

	// fixed port field widths
	localparam int KEY_BITS       = 8;
	localparam int SCORE_IN_BITS  = 32;
	localparam int TRACE_BITS     = 32;
	localparam int CFG_INDEX_BITS = 8;
	localparam int CFG_DATA_BITS  = 8;
	localparam int COUNT_BITS     = 9;
	localparam int S_TDATA_BITS   = 72;

	// input tdata layout
	localparam int S_KEY_LSB   = 0;
	localparam int S_SCORE_LSB = 8;
	localparam int S_TRACE_LSB = 40;

	// configuration register indexes
	localparam logic [CFG_INDEX_BITS-1:0] REG_KNOWN_KEY = 8'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_ORDER     = 8'd1;

	localparam logic [CFG_DATA_BITS-1:0] KNOWN_KEY_RST = 8'd0;
	localparam logic [CFG_DATA_BITS-1:0] ORDER_RST     = 8'd1;

	typedef enum logic [2:0] {
		ST_RUN,
		ST_LAST,
		ST_REF,
		ST_SWEEP,
		ST_OUT
	} rank_state_t;

endpackage

>>> hdl/key_rank_success_check.sv
// Key rank success check: per-key running maxima in one RAM, ranking sweep
// at the end of each step. Depends on krsc_pkg.
//
//  channel | direction | handshake          | payload
//  s_*     | in        | s_tvalid/s_tready  | tdata key,score,traces; tuser row_start; tlast
//  m_*     | out       | m_tvalid/m_tready  | tdata traces_used; tuser success
//  cfg_*   | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// Ordinary samples go at one per cycle while s_tready is high: read-modify-write
// of the maxima RAM, with the write forwarded to a read of the same entry at that edge.
// A step_last request holds s_tready low through LAST, REF, a sweep of every
// entry through the single read port, and OUT, longer while an older result
// still waits; its result is loaded into the output register in OUT. With
// known_key out of range the sweep is skipped and LAST goes straight to OUT.
// Reset clears control and configuration only; the RAM is not cleared.
module key_rank_success_check
	import krsc_pkg::*;
#(
	parameter int KEY_COUNT  = KEY_COUNT_DEF,
	parameter int SCORE_BITS = SCORE_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [S_TDATA_BITS-1:0]   s_tdata,   // key_hypothesis[7:0], score[39:8],
	                                             // traces[71:40]
	input  logic                      s_tuser,   // row_start
	input  logic                      s_tlast,   // step_last
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [TRACE_BITS-1:0]     m_tdata,   // traces_used[31:0]
	output logic                      m_tuser,   // success
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

	localparam int SW = (SCORE_BITS < SCORE_IN_BITS) ? SCORE_BITS : SCORE_IN_BITS;
	localparam int KW = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
	localparam logic [KEY_BITS:0] KEY_LIMIT = (KEY_BITS+1)'(KEY_COUNT);
	localparam logic [KW:0]       IDX_END   = (KW+1)'(KEY_COUNT);

	rank_state_t state_q, state_d;

	logic [CFG_DATA_BITS-1:0] known_q, order_q;

	// sample stage
	logic                   valid_s1, start_s1, key_ok_s1;
	logic [KW-1:0]          key_s1;
	logic signed [SW-1:0]   score_s1;
	logic [TRACE_BITS-1:0]  trace_s1;

	// maxima RAM
	logic signed [SW-1:0]   mem [KEY_COUNT];
	logic [KW-1:0]          rd_addr;
	logic signed [SW-1:0]   rd_q, rdata, new_max;
	logic                   wr_en;
	logic                   fwd_q;
	logic signed [SW-1:0]   fwd_data_q;

	// ranking
	logic signed [SW-1:0]   ref_q;
	logic [KW:0]            idx_q;
	logic [COUNT_BITS-1:0]  gcount_q;
	logic                   known_ok;
	logic                   out_load;

	logic                   m_tvalid_q, m_tuser_q;
	logic [TRACE_BITS-1:0]  m_tdata_q;

	logic s_accept;
	logic [KEY_BITS-1:0] s_key;

	assign s_accept  = s_tvalid & s_tready;
	assign s_key     = s_tdata[S_KEY_LSB +: KEY_BITS];
	assign cfg_ready = 1'b1;
	assign known_ok  = {1'b0, known_q} < KEY_LIMIT;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			known_q <= KNOWN_KEY_RST;
			order_q <= ORDER_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_KNOWN_KEY: known_q <= cfg_data;
				REG_ORDER:     order_q <= cfg_data;
				default:       ;
			endcase
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_RUN:   if (s_accept && s_tlast) state_d = ST_LAST;
			ST_LAST:  state_d = known_ok ? ST_REF : ST_OUT;
			ST_REF:   state_d = ST_SWEEP;
			ST_SWEEP: if (idx_q == IDX_END) state_d = ST_OUT;
			ST_OUT:   if (!m_tvalid_q || m_tready) state_d = ST_RUN;
			default:  state_d = ST_RUN;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		s_tready = 1'b0;
		out_load = 1'b0;
		rd_addr  = s_key[KW-1:0];
		case (state_q)
			ST_RUN:   s_tready = 1'b1;
			ST_LAST:  rd_addr  = known_q[KW-1:0];
			ST_REF:   rd_addr  = '0;
			ST_SWEEP: rd_addr  = (idx_q == IDX_END) ? '0 : idx_q[KW-1:0];
			ST_OUT:   out_load = !m_tvalid_q || m_tready;
			default:  ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_RUN;
			valid_s1 <= 1'b0;
		end else begin
			state_q  <= state_d;
			valid_s1 <= s_accept;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			key_s1    <= s_key[KW-1:0];
			key_ok_s1 <= {1'b0, s_key} < KEY_LIMIT;
			score_s1  <= s_tdata[S_SCORE_LSB +: SW];
			start_s1  <= s_tuser;
			trace_s1  <= s_tdata[S_TRACE_LSB +: TRACE_BITS];
		end
	end

	// read data, patched when the same entry was written at the read edge
	assign rdata   = fwd_q ? fwd_data_q : rd_q;
	assign new_max = (start_s1 || (score_s1 > rdata)) ? score_s1 : rdata;
	assign wr_en   = valid_s1 && key_ok_s1;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[key_s1] <= new_max;
		end
		rd_q       <= mem[rd_addr];
		fwd_data_q <= new_max;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
		end else begin
			fwd_q <= wr_en && (key_s1 == rd_addr);
		end
	end

	// ranking sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= '0;
			gcount_q <= '0;
		end else begin
			case (state_q)
				ST_LAST: gcount_q <= '0;
				ST_REF:  idx_q    <= (KW+1)'(1);
				ST_SWEEP: begin
					if (rdata > ref_q) gcount_q <= gcount_q + COUNT_BITS'(1);
					if (idx_q != IDX_END) idx_q <= idx_q + (KW+1)'(1);
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_REF) ref_q <= rdata;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= trace_s1;
			m_tuser_q <= known_ok && (gcount_q < {1'b0, order_q});
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

`ifndef ASSERT_OFF
	// a step's final sample is written while the sequencer sits in LAST
	a_last_in_s1: assert property (@(posedge clk) disable iff (!arst_n)
		$past(s_accept && s_tlast) |-> state_q == ST_LAST)
		else $error("final sample not followed by ranking");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		gcount_q < COUNT_BITS'(KEY_COUNT))
		else $error("greater count beyond key count");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= IDX_END)
		else $error("sweep index overrun");

	a_sweep_started: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SWEEP |-> idx_q != '0)
		else $error("sweep entered without reference read");

	a_no_write_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_REF || state_q == ST_SWEEP) |-> !valid_s1)
		else $error("maxima written during ranking");
`endif

endmodule

>>> bench/tb_top.sv
// Testbench for key_rank_success_check: streams score samples, predicts the
// rank of the known key at each step end and checks every result.
// Depends on krsc_pkg and the key_rank_success_check RTL only.
module tb_top
	import krsc_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int HOLD_CYCLES = 2000;
	localparam int IDLE_LIMIT  = 20000;
	localparam int SETTLE      = KEY_COUNT_DEF + 8;
	localparam int RANDOM_ITEMS = 250;

	typedef struct packed {
		logic [TRACE_BITS-1:0] traces;
		logic                  success;
	} step_result_t;

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      s_tvalid = 1'b0;
	logic                      s_tready;
	logic [S_TDATA_BITS-1:0]   s_tdata = '0;
	logic                      s_tuser = 1'b0;
	logic                      s_tlast = 1'b0;
	logic                      m_tvalid;
	logic                      m_tready = 1'b0;
	logic [TRACE_BITS-1:0]     m_tdata;
	logic                      m_tuser;
	logic                      cfg_valid = 1'b0;
	logic                      cfg_ready;
	logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
	logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

	// predictor state
	logic signed [SCORE_IN_BITS-1:0] key_max [KEY_COUNT_DEF];
	logic [CFG_DATA_BITS-1:0]        rank_known_key = KNOWN_KEY_RST;
	logic [CFG_DATA_BITS-1:0]        rank_order     = ORDER_RST;
	step_result_t                    step_results_q [$];
	step_result_t                    result_want;

	int error_count = 0;
	int idle_cycles = 0;
	int burst_left  = 0;
	bit sender_steady = 1'b0;

	// receiver stall control
	int hold_asked  = 0;
	int hold_served = 0;
	int hold_left   = 0;
	int stall_mode  = 0;
	int stall_phase = 0;

	key_rank_success_check uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		error_count++;
		$display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
	endtask

	// rank = keys strictly above the known key, plus one; ties go to the known key
	function automatic bit rank_within_order();
		int unsigned above;
		above = 0;
		for (int j = 0; j < KEY_COUNT_DEF; j++)
			if (key_max[j] > key_max[rank_known_key])
				above++;
		return (above + 1) <= rank_order;
	endfunction

	task automatic send_sample(input logic [KEY_BITS-1:0] key,
			input logic signed [SCORE_IN_BITS-1:0] score, input bit row_start,
			input bit step_last, input logic [TRACE_BITS-1:0] trace_total);
		int gap;
		step_result_t res;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = (sender_steady || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata  <= {trace_total, score, key};
		s_tuser  <= row_start;
		s_tlast  <= step_last;
		do @(posedge clk); while (!s_tready);
		if (row_start || score > key_max[key])
			key_max[key] = score;
		if (step_last) begin
			res.traces  = trace_total;
			res.success = rank_within_order();
			step_results_q.push_back(res);
		end
	endtask

	// lets every request drain, then gives the ranking sweep time to finish
	task automatic settle_block();
		s_tvalid <= 1'b0;
		while (step_results_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic configure(input logic [CFG_DATA_BITS-1:0] known,
			input logic [CFG_DATA_BITS-1:0] ord);
		settle_block();
		cfg_valid <= 1'b1;
		cfg_index <= REG_KNOWN_KEY;
		cfg_data  <= known;
		do @(posedge clk); while (!cfg_ready);
		cfg_index <= REG_ORDER;
		cfg_data  <= ord;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		rank_known_key = known;
		rank_order     = ord;
	endtask

	// every entry must be written before the first ranking; all keys tie here
	task automatic test_fill_ties();
		for (int k = 0; k < KEY_COUNT_DEF; k++)
			send_sample(k[KEY_BITS-1:0], 32'sh8000_0000, 1'b1, k == KEY_COUNT_DEF - 1,
				$urandom);
	endtask

	task automatic test_score_extremes();
		send_sample(8'd0,   32'sh7fff_ffff, 1'b1, 1'b0, 32'h0);
		send_sample(8'd1,   32'sh8000_0000, 1'b1, 1'b0, 32'h0);
		send_sample(8'd0,   32'sh8000_0000, 1'b0, 1'b0, 32'h0);   // must not lower the max
		send_sample(8'd255, 32'sh7fff_ffff, 1'b1, 1'b1, 32'hffff_ffff); // tie at the top
		send_sample(8'd0,   32'shffff_ffff, 1'b1, 1'b0, 32'h0);   // restart lowers it
		send_sample(8'd200, 32'sh0000_0000, 1'b0, 1'b0, 32'h0);
		send_sample(8'd255, 32'sh7fff_ffff, 1'b1, 1'b1, 32'h0);
	endtask

	task automatic test_registers();
		configure(8'd255, 8'd255);
		send_sample(8'd255, 32'sh8000_0000, 1'b1, 1'b1, 32'h5a5a_a5a5);
		configure(8'd255, 8'd0);   // order zero never succeeds
		send_sample(8'd255, 32'sh7fff_ffff, 1'b1, 1'b1, 32'ha5a5_5a5a);
		configure(8'd128, 8'd1);
		send_sample(8'd128, 32'sh7fff_ffff, 1'b1, 1'b1, 32'h1234_5678);
		send_sample(8'd17,  32'sh7fff_fffe, 1'b1, 1'b1, 32'h8765_4321);
	endtask

	// receiver holds off while whole steps keep arriving
	task automatic test_output_stall();
		settle_block();
		hold_asked    <= hold_asked + 1;
		sender_steady = 1'b1;
		for (int i = 0; i < 24; i++)
			send_sample(8'($urandom), $urandom, 1'($urandom_range(0, 1)), (i % 6) == 5,
				$urandom);
		sender_steady = 1'b0;
	endtask

	task automatic send_random_step(input int len);
		int  score_mode;
		bit  broken;
		bit  seen [KEY_COUNT_DEF];
		bit  rs;
		logic [KEY_BITS-1:0]             k;
		logic signed [SCORE_IN_BITS-1:0] sc;
		score_mode = $urandom_range(0, 3);
		broken     = $urandom_range(0, 9) < 2;
		for (int i = 0; i < len; i++) begin
			k = ($urandom_range(0, 3) == 0) ? rank_known_key : 8'($urandom_range(0, 255));
			case (score_mode)
				0: sc = $urandom;
				1: sc = int'($urandom_range(0, 8)) - 4;   // narrow range, many ties
				2: begin
					case ($urandom_range(0, 3))
						0: sc = 32'sh8000_0000;
						1: sc = 32'sh7fff_ffff;
						2: sc = -1;
						default: sc = 0;
					endcase
				end
				default: sc = (k == rank_known_key) ?
					32'sh7fff_fff0 + int'($urandom_range(0, 15)) : $urandom;
			endcase
			if (broken)
				rs = 1'($urandom_range(0, 1));
			else
				rs = !seen[k] ? ($urandom_range(0, 9) < 8) : ($urandom_range(0, 9) == 0);
			seen[k] = 1'b1;
			send_sample(k, sc, rs, i == len - 1, $urandom);
		end
	endtask

	task automatic test_random_steps();
		int sent;
		int since_cfg;
		int len;
		logic [CFG_DATA_BITS-1:0] known;
		logic [CFG_DATA_BITS-1:0] ord;
		sent      = 0;
		since_cfg = 0;
		while (sent < RANDOM_ITEMS) begin
			if (since_cfg >= 120) begin
				case ($urandom_range(0, 3))
					0: known = 8'd0;
					1: known = 8'd255;
					default: known = 8'($urandom_range(0, 255));
				endcase
				case ($urandom_range(0, 4))
					0: ord = 8'd0;
					1: ord = 8'd1;
					2: ord = 8'd255;
					default: ord = 8'($urandom_range(1, 255));
				endcase
				configure(known, ord);
				since_cfg = 0;
			end
			len = ($urandom_range(0, 6) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 14);
			sender_steady = $urandom_range(0, 4) == 0;
			send_random_step(len);
			sent      += len;
			since_cfg += len;
		end
		sender_steady = 1'b0;
	endtask

	always @(posedge clk) begin
		if (hold_left != 0) begin
			m_tready  <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_served != hold_asked) begin
			m_tready    <= 1'b0;
			hold_left   <= HOLD_CYCLES;
			hold_served <= hold_served + 1;
		end else begin
			if (stall_phase == 0) begin
				stall_mode  <= $urandom_range(0, 3);
				stall_phase <= $urandom_range(16, 200);
			end else begin
				stall_phase <= stall_phase - 1;
			end
			case (stall_mode)
				0: m_tready <= 1'b1;
				1: m_tready <= 1'($urandom_range(0, 1));
				2: m_tready <= $urandom_range(0, 3) == 0;
				default: m_tready <= stall_phase[2];
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (step_results_q.size() == 0) begin
				report_mismatch("result with nothing pending", 64'({m_tuser, m_tdata}),
					64'h0);
			end else begin
				result_want = step_results_q.pop_front();
				if (m_tdata !== result_want.traces)
					report_mismatch("traces_used", 64'(m_tdata), 64'(result_want.traces));
				if (m_tuser !== result_want.success)
					report_mismatch("success", 64'(m_tuser), 64'(result_want.success));
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb_top: done, errors");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		arst_n <= 1'b0;
		for (int k = 0; k < KEY_COUNT_DEF; k++)
			key_max[k] = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_fill_ties();
		test_score_extremes();
		test_registers();
		test_output_stall();
		test_random_steps();
		settle_block();
		if (error_count == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule
